// ===== rtl/rsu_pkg.sv =====
// Shared types and constants for the running statistics block.
`default_nettype none
package rsu_pkg;

  localparam int COUNT_WIDTH_DEF  = 32;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  // width of every exact intermediate
  localparam int WIDE_W = 128;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  localparam logic [1:0] CFG_SEED_COUNT     = 2'd0;
  localparam logic [1:0] CFG_SEED_MEAN      = 2'd1;
  localparam logic [1:0] CFG_SEED_HARMONIC  = 2'd2;
  localparam logic [1:0] CFG_SEED_DEVIATION = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_HELD = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/rsu_if.sv =====
// Valid/ready channel interfaces for samples in and statistics out.
`default_nettype none
interface rsu_in_if #(parameter int SAMPLE_WIDTH = rsu_pkg::SAMPLE_WIDTH_DEF) ();
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  modport source (output valid, op, sample, input ready);
  modport sink   (input valid, op, sample, output ready);
endinterface

interface rsu_out_if ();
  logic               valid;
  logic               ready;
  logic        [31:0] count;
  logic        [31:0] std_dev;
  logic signed [31:0] arith_mean;
  logic        [31:0] rms;
  logic signed [31:0] hmean;
  logic        [1:0]  status;
  modport source (output valid, count, std_dev, arith_mean, rms, hmean, status,
                  input ready);
  modport sink   (input valid, count, std_dev, arith_mean, rms, hmean, status,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/rsu_alu.sv =====
// Shared bit-serial unit: shift-add multiply, restoring divide, digit square root.
`default_nettype none
module rsu_alu #(
  parameter int MUL_STEPS = 34
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rsu_pkg::alu_req_t             req,
  input  wire logic [rsu_pkg::WIDE_W-1:0]    a,
  input  wire logic [rsu_pkg::WIDE_W-1:0]    b,
  output logic      [rsu_pkg::WIDE_W-1:0]    res,
  output logic                               done
);
  localparam int W    = rsu_pkg::WIDE_W;
  localparam int CNTW = $clog2(W + 1);

  logic [W-1:0]    x_r, y_r, q_r, res_r;
  logic [W:0]      acc_r;
  logic [CNTW-1:0] cnt_r;
  rsu_pkg::alu_op_t op_r;
  logic            busy_r, done_r;

  logic [W:0] rem_div, rem_sq, trial_sq;

  assign rem_div  = {acc_r[W-1:0], x_r[W-1]};
  assign rem_sq   = {acc_r[W-2:0], x_r[W-1:W-2]};
  assign trial_sq = {q_r[W-2:0], 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        y_r    <= b;
        acc_r  <= '0;
        q_r    <= '0;
        case (req.op)
          rsu_pkg::ALU_SQRT: begin
            x_r   <= {a[W/2-1:0], {(W/2){1'b0}}};
            cnt_r <= CNTW'(W / 4);
          end
          rsu_pkg::ALU_DIV: begin
            x_r   <= a;
            cnt_r <= CNTW'(W);
          end
          default: begin
            x_r   <= a;
            cnt_r <= CNTW'(MUL_STEPS);
          end
        endcase
      end else if (busy_r && cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        case (op_r)
          rsu_pkg::ALU_DIV: begin
            x_r <= x_r << 1;
            if (rem_div >= {1'b0, y_r}) begin
              acc_r <= rem_div - {1'b0, y_r};
              q_r   <= {q_r[W-2:0], 1'b1};
            end else begin
              acc_r <= rem_div;
              q_r   <= {q_r[W-2:0], 1'b0};
            end
          end
          rsu_pkg::ALU_SQRT: begin
            x_r <= x_r << 2;
            if (rem_sq >= trial_sq) begin
              acc_r <= rem_sq - trial_sq;
              q_r   <= {q_r[W-2:0], 1'b1};
            end else begin
              acc_r <= rem_sq;
              q_r   <= {q_r[W-2:0], 1'b0};
            end
          end
          default: begin
            if (y_r[0]) acc_r <= {1'b0, acc_r[W-1:0] + x_r};
            x_r <= x_r << 1;
            y_r <= y_r >> 1;
          end
        endcase
      end else if (busy_r) begin
        // round the quotient or root, then hand back
        busy_r <= 1'b0;
        case (op_r)
          rsu_pkg::ALU_DIV:
            res_r <= q_r + W'(acc_r[W-1:0] >= y_r - acc_r[W-1:0]);
          rsu_pkg::ALU_SQRT:
            res_r <= q_r + W'(acc_r > {1'b0, q_r});
          default:
            res_r <= acc_r[W-1:0];
        endcase
      end
    end
  end

  assign res  = res_r;
  assign done = done_r;
endmodule
`default_nettype wire

// ===== rtl/running_statistics_update.sv =====
// Running statistics: count, Welford mean and deviation, rms and harmonic mean.
// One sample runs entirely on the single bit-serial unit in rsu_alu: nine shift-add
// multiplies of max(SAMPLE_WIDTH+FRAC_BITS, 32)+2 or COUNT_WIDTH steps, whichever is
// more, each with a launch and a hand-back, four 128-bit restoring divides and two
// square roots, plus the accept, harmonic-case pick and commit states. A harmonic mean
// held or set from the first sample at the case pick skips the last four steps, one
// held at a zero denominator skips the last three, and a saturated quotient skips its root.
// A restart word goes straight from accept to commit. A new word is taken whenever the
// sequencer is idle, even while the previous result still waits in the output register;
// the commit then waits until that result has been taken.
`default_nettype none
module running_statistics_update #(
  parameter int COUNT_WIDTH  = rsu_pkg::COUNT_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = rsu_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = rsu_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rsu_in_if.sink           in_chan,
  rsu_out_if.source        out_chan,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int W  = rsu_pkg::WIDE_W;
  localparam int XW = SAMPLE_WIDTH + FRAC_BITS;
  localparam int DW = ((XW > 32) ? XW : 32) + 2;
  localparam int BW = (DW > COUNT_WIDTH) ? DW : COUNT_WIDTH;

  typedef enum logic [17:0] {
    ST_IDLE = 18'h00001, ST_DEV2 = 18'h00002, ST_MDIV = 18'h00004,
    ST_MSQ  = 18'h00008, ST_XSQ  = 18'h00010, ST_RMSM = 18'h00020,
    ST_RMSD = 18'h00040, ST_RMSQ = 18'h00080, ST_WACC = 18'h00100,
    ST_WP   = 18'h00200, ST_WDIV = 18'h00400, ST_WSQ  = 18'h00800,
    ST_HSEL = 18'h01000, ST_TA   = 18'h02000, ST_NUM1 = 18'h04000,
    ST_NUM2 = 18'h08000, ST_HDIV = 18'h10000, ST_DONE = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] s_cnt_r, s_mean_r, s_harm_r, s_dev_r;
  logic [COUNT_WIDTH-1:0] cnt_r, n_r, c_r;
  logic [31:0] mean_r, harm_r, dev_r;
  logic [31:0] mnew_r, harmn_r, devn_r, rms_r;
  logic [XW-1:0] xm_r;
  logic xneg_r, sat_r, held_r, hsign_r, launched_r, out_valid_r;
  logic [63:0] dev2_r;
  logic [W-1:0] acc_r, t_r;
  logic [31:0] o_count_r, o_std_r, o_mean_r, o_rms_r, o_harm_r;
  logic [1:0]  o_stat_r;

  rsu_pkg::alu_req_t req;
  logic [W-1:0] alu_a, alu_b, alu_res;
  logic alu_done;

  rsu_alu #(.MUL_STEPS(BW)) u_alu (
    .clk(clk), .rst_n(rst_n), .req(req), .a(alu_a), .b(alu_b),
    .res(alu_res), .done(alu_done)
  );

  // signed views of the work values
  logic signed [DW-1:0] mold_s, xq_s, diff_s, a_s;
  logic [DW-1:0] diff_mag, a_mag;
  logic [31:0] mold_mag, hm;
  logic signed [DW:0] msum;
  logic hneg, samp_sign, in_acc;
  logic [SAMPLE_WIDTH-1:0] samp_mag;
  logic [W-1:0] den;
  logic dneg;

  assign mold_s   = DW'($signed(mean_r));
  assign xq_s     = xneg_r ? -$signed(DW'(xm_r)) : $signed(DW'(xm_r));
  assign diff_s   = xq_s - mold_s;
  assign a_s      = xq_s - DW'($signed(mnew_r));
  assign diff_mag = diff_s[DW-1] ? DW'(-diff_s) : DW'(diff_s);
  assign a_mag    = a_s[DW-1] ? DW'(-a_s) : DW'(a_s);
  assign mold_mag = mean_r[31] ? -mean_r : mean_r;
  assign hneg     = harm_r[31];
  assign hm       = hneg ? -harm_r : harm_r;
  assign msum     = diff_s[DW-1] ? ({mold_s[DW-1], mold_s} - $signed({1'b0, alu_res[DW-1:0]}))
                                 : ({mold_s[DW-1], mold_s} + $signed({1'b0, alu_res[DW-1:0]}));
  assign samp_sign = in_chan.sample[SAMPLE_WIDTH-1];
  assign samp_mag  = samp_sign ? SAMPLE_WIDTH'(-in_chan.sample) : SAMPLE_WIDTH'(in_chan.sample);
  assign in_acc    = in_chan.valid && in_chan.ready;

  // reciprocal-sum denominator from c*x and the old harmonic mean
  always_comb begin
    if (xneg_r == hneg) begin
      den  = alu_res + W'(hm);
      dneg = xneg_r;
    end else if (alu_res >= W'(hm)) begin
      den  = alu_res - W'(hm);
      dneg = xneg_r;
    end else begin
      den  = W'(hm) - alu_res;
      dneg = hneg;
    end
  end

  function automatic logic [32:0] pack_s32(input logic [W-1:0] m, input logic neg);
    logic over;
    over = (|m[W-1:32]) || (neg ? (m[31] && |m[30:0]) : m[31]);
    if (over) pack_s32 = {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
    else      pack_s32 = {1'b0, neg ? -m[31:0] : m[31:0]};
  endfunction

  logic [32:0] hpack, xpack;
  assign hpack = pack_s32(alu_res, hsign_r);
  assign xpack = pack_s32(W'(xm_r), xneg_r);

  // operands for each step
  always_comb begin
    req.start = 1'b0;
    req.op    = rsu_pkg::ALU_MUL;
    alu_a     = '0;
    alu_b     = '0;
    case (state_r)
      ST_DEV2: begin alu_a = W'(dev_r); alu_b = W'(dev_r); end
      ST_MDIV: begin req.op = rsu_pkg::ALU_DIV; alu_a = W'(diff_mag); alu_b = W'(n_r); end
      ST_MSQ:  begin alu_a = W'(mold_mag); alu_b = W'(mold_mag); end
      ST_XSQ:  begin alu_a = W'(xm_r); alu_b = W'(xm_r); end
      ST_RMSM: begin alu_a = acc_r; alu_b = W'(c_r); end
      ST_RMSD: begin req.op = rsu_pkg::ALU_DIV; alu_a = acc_r; alu_b = W'(n_r); end
      ST_RMSQ: begin req.op = rsu_pkg::ALU_SQRT; alu_a = t_r; end
      ST_WACC: begin alu_a = W'(dev2_r); alu_b = W'(c_r); end
      ST_WP:   begin alu_a = W'(a_mag); alu_b = W'(diff_mag); end
      ST_WDIV: begin req.op = rsu_pkg::ALU_DIV; alu_a = acc_r; alu_b = W'(n_r); end
      ST_WSQ:  begin req.op = rsu_pkg::ALU_SQRT; alu_a = t_r; end
      ST_TA:   begin alu_a = W'(xm_r); alu_b = W'(c_r); end
      ST_NUM1: begin alu_a = W'(hm); alu_b = W'(n_r); end
      ST_NUM2: begin alu_a = t_r; alu_b = W'(xm_r); end
      ST_HDIV: begin req.op = rsu_pkg::ALU_DIV; alu_a = t_r; alu_b = acc_r; end
      default: ;
    endcase
    req.start = !launched_r && (state_r != ST_IDLE) && (state_r != ST_HSEL)
                && (state_r != ST_DONE);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = in_chan.op ? ST_DONE : ST_DEV2;
      ST_DEV2: if (alu_done) state_nxt = ST_MDIV;
      ST_MDIV: if (alu_done) state_nxt = ST_MSQ;
      ST_MSQ:  if (alu_done) state_nxt = ST_XSQ;
      ST_XSQ:  if (alu_done) state_nxt = ST_RMSM;
      ST_RMSM: if (alu_done) state_nxt = ST_RMSD;
      ST_RMSD: if (alu_done) state_nxt = (|alu_res[W-1:64]) ? ST_WACC : ST_RMSQ;
      ST_RMSQ: if (alu_done) state_nxt = ST_WACC;
      ST_WACC: if (alu_done) state_nxt = ST_WP;
      ST_WP:   if (alu_done) state_nxt = ST_WDIV;
      ST_WDIV: if (alu_done) state_nxt = (|alu_res[W-1:64]) ? ST_HSEL : ST_WSQ;
      ST_WSQ:  if (alu_done) state_nxt = ST_HSEL;
      ST_HSEL: state_nxt = (xm_r == '0 || c_r == '0 || harm_r == '0) ? ST_DONE : ST_TA;
      ST_TA:   if (alu_done) state_nxt = (den == '0) ? ST_DONE : ST_NUM1;
      ST_NUM1: if (alu_done) state_nxt = ST_NUM2;
      ST_NUM2: if (alu_done) state_nxt = ST_HDIV;
      ST_HDIV: if (alu_done) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      mean_r      <= '0;
      harm_r      <= '0;
      dev_r       <= '0;
      s_cnt_r     <= '0;
      s_mean_r    <= '0;
      s_harm_r    <= '0;
      s_dev_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (req.start) launched_r <= 1'b1;
      else if (alu_done) launched_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          rsu_pkg::CFG_SEED_COUNT:     s_cnt_r  <= cfg_data;
          rsu_pkg::CFG_SEED_MEAN:      s_mean_r <= cfg_data;
          rsu_pkg::CFG_SEED_HARMONIC:  s_harm_r <= cfg_data;
          rsu_pkg::CFG_SEED_DEVIATION: s_dev_r  <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_DONE && (!out_valid_r || out_chan.ready)) begin
        // commit the new state and present the word
        out_valid_r <= 1'b1;
        cnt_r       <= n_r;
        mean_r      <= mnew_r;
        harm_r      <= harmn_r;
        dev_r       <= devn_r;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      sat_r  <= !in_chan.op && (&cnt_r);
      held_r <= 1'b0;
      if (in_chan.op) begin
        n_r     <= COUNT_WIDTH'(s_cnt_r);
        mnew_r  <= s_mean_r;
        harmn_r <= s_harm_r;
        devn_r  <= s_dev_r;
        rms_r   <= '0;
      end else begin
        xneg_r  <= samp_sign;
        xm_r    <= XW'(samp_mag) << FRAC_BITS;
        harmn_r <= harm_r;
        if (&cnt_r) begin
          n_r <= cnt_r;
          c_r <= cnt_r - 1'b1;
        end else begin
          n_r <= cnt_r + 1'b1;
          c_r <= cnt_r;
        end
      end
    end
    if (alu_done) begin
      case (state_r)
        ST_DEV2: dev2_r <= alu_res[63:0];
        ST_MDIV: begin
          if (msum[DW:31] != '0 && msum[DW:31] != '1) begin
            sat_r  <= 1'b1;
            mnew_r <= msum[DW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else begin
            mnew_r <= msum[31:0];
          end
        end
        ST_MSQ:  acc_r <= W'(dev2_r) + alu_res;
        ST_XSQ:  t_r <= alu_res;
        ST_RMSM: acc_r <= alu_res + t_r;
        ST_RMSD: begin
          t_r <= alu_res;
          if (|alu_res[W-1:64]) begin
            rms_r <= '1;
            sat_r <= 1'b1;
          end
        end
        ST_RMSQ: begin
          if (alu_res[32]) begin
            rms_r <= '1;
            sat_r <= 1'b1;
          end else begin
            rms_r <= alu_res[31:0];
          end
        end
        ST_WACC: acc_r <= alu_res;
        ST_WP: begin
          // opposite signs subtract the cross term, clamped at zero
          if (a_s[DW-1] != diff_s[DW-1]) acc_r <= (alu_res > acc_r) ? '0 : acc_r - alu_res;
          else acc_r <= acc_r + alu_res;
        end
        ST_WDIV: begin
          t_r <= alu_res;
          if (|alu_res[W-1:64]) begin
            devn_r <= '1;
            sat_r  <= 1'b1;
          end
        end
        ST_WSQ: begin
          if (alu_res[32]) begin
            devn_r <= '1;
            sat_r  <= 1'b1;
          end else begin
            devn_r <= alu_res[31:0];
          end
        end
        ST_TA: begin
          acc_r   <= den;
          hsign_r <= (hneg != xneg_r) != dneg;
          if (den == '0) held_r <= 1'b1;
        end
        ST_NUM1: t_r <= alu_res;
        ST_NUM2: t_r <= alu_res;
        ST_HDIV: begin
          harmn_r <= hpack[31:0];
          if (hpack[32]) sat_r <= 1'b1;
        end
        default: ;
      endcase
    end
    if (state_r == ST_HSEL) begin
      if (xm_r == '0) begin
        held_r <= 1'b1;
      end else if (c_r == '0) begin
        harmn_r <= xpack[31:0];
        if (xpack[32]) sat_r <= 1'b1;
      end else if (harm_r == '0) begin
        held_r <= 1'b1;
      end
    end
    if (state_r == ST_DONE && (!out_valid_r || out_chan.ready)) begin
      o_count_r <= 32'(n_r);
      o_std_r   <= devn_r;
      o_mean_r  <= mnew_r;
      o_rms_r   <= rms_r;
      o_harm_r  <= harmn_r;
      o_stat_r  <= held_r ? rsu_pkg::STAT_HELD : (sat_r ? rsu_pkg::STAT_SAT : rsu_pkg::STAT_OK);
    end
  end

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.count      = o_count_r;
  assign out_chan.std_dev    = o_std_r;
  assign out_chan.arith_mean = o_mean_r;
  assign out_chan.rms        = o_rms_r;
  assign out_chan.hmean      = o_harm_r;
  assign out_chan.status     = o_stat_r;

  a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> launched_r)
    else $error("arithmetic unit finished without a launch");

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_chan.op) |=> state_r == ST_DEV2)
    else $error("sample word did not start the sequence");

  a_restart_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.op) |=> state_r == ST_DONE)
    else $error("restart word did not go straight to the result");

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state lost its one-hot code");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for running_statistics_update: predicted statistics per input word.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int        CW          = rsu_pkg::COUNT_WIDTH_DEF;
  localparam int        SW          = rsu_pkg::SAMPLE_WIDTH_DEF;
  localparam int        FB          = rsu_pkg::FRAC_BITS_DEF;
  localparam logic      OP_SAMPLE   = 1'b0;
  localparam logic      OP_RESTART  = 1'b1;
  localparam int        SETTLE      = 1000;
  localparam longint    CYCLE_LIMIT = 40_000_000;
  localparam logic [63:0] COUNT_MAX = (64'd1 << CW) - 64'd1;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] std_dev;
    logic [31:0] arith_mean;
    logic [31:0] rms;
    logic [31:0] hmean;
    logic [1:0]  status;
  } stats_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = rsu_pkg::CFG_SEED_COUNT;
  logic [31:0] cfg_data = '0;

  rsu_in_if  in_ch ();
  rsu_out_if out_ch ();

  running_statistics_update DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state and seeds
  logic [63:0] st_count;
  logic [31:0] st_mean, st_harm, st_dev;
  logic [31:0] sd_count, sd_mean, sd_harm, sd_dev;

  stats_t expected_stats[$];
  int     errors = 0;
  longint cycles = 0;
  bit     idle_on = 1'b1;
  int     hold_off = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_SAMPLE;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [127:0] div_nearest(input logic [127:0] n, input logic [127:0] d);
    logic [127:0] q, r;
    q = n / d;
    r = n % d;
    return (r >= d - r) ? q + 128'd1 : q;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] root_nearest(input logic [127:0] num, input logic [63:0] n,
                                              inout bit sat);
    logic [127:0] v;
    logic [63:0]  r;
    v = div_nearest(num, 128'(n));
    if (v[127:64] != 0) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    r = isqrt64(v[63:0]);
    if (v[63:0] - r * r > r) r = r + 1;
    if (r > 64'hFFFF_FFFF) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] clamp_signed(input logic [127:0] m, input bit neg,
                                              inout bit sat);
    logic [127:0] lim;
    logic [31:0]  t;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (m > lim) begin
      sat = 1'b1;
      m = lim;
    end
    t = m[31:0];
    return neg ? ~t + 32'd1 : t;
  endfunction

  function automatic stats_t update_stats(input logic op, input logic signed [SW-1:0] sample);
    stats_t       res;
    bit           sat, held, xneg, hneg, dneg;
    longint       x, xq, mold, mnew, diff, v, a, b, hold;
    logic [63:0]  n, c, xm, hm, q;
    logic [31:0]  rms;
    logic [127:0] dev2, acc, p, ta, tb, den, num;
    sat = 1'b0;
    held = 1'b0;
    if (op == OP_RESTART) begin
      st_count = 64'(sd_count) & COUNT_MAX;
      st_mean = sd_mean;
      st_harm = sd_harm;
      st_dev = sd_dev;
      res.count = st_count[31:0];
      res.std_dev = st_dev;
      res.arith_mean = st_mean;
      res.rms = '0;
      res.hmean = st_harm;
      res.status = rsu_pkg::STAT_OK;
      return res;
    end
    x = longint'(sample);
    xneg = x < 0;
    xm = magnitude(x) << FB;
    xq = xneg ? -longint'(xm) : longint'(xm);
    if (st_count >= COUNT_MAX) begin
      n = COUNT_MAX;
      sat = 1'b1;
    end else begin
      n = st_count + 1;
    end
    c = n - 1;
    mold = longint'(signed'(st_mean));
    dev2 = 128'(st_dev) * 128'(st_dev);

    diff = xq - mold;
    q = 64'(div_nearest(128'(magnitude(diff)), 128'(n)));
    v = diff < 0 ? mold - longint'(q) : mold + longint'(q);
    mnew = longint'(signed'(clamp_signed(128'(magnitude(v)), v < 0, sat)));

    // rms uses the old mean and old deviation
    acc = dev2 + 128'(magnitude(mold)) * 128'(magnitude(mold));
    acc = acc * 128'(c) + 128'(xm) * 128'(xm);
    rms = root_nearest(acc, n, sat);

    a = xq - mnew;
    b = xq - mold;
    acc = dev2 * 128'(c);
    p = 128'(magnitude(a)) * 128'(magnitude(b));
    if ((a < 0) != (b < 0) && a != 0 && b != 0) acc = (p > acc) ? '0 : acc - p;
    else acc = acc + p;
    st_dev = root_nearest(acc, n, sat);

    hold = longint'(signed'(st_harm));
    if (x == 0) begin
      held = 1'b1;
    end else if (c == 0) begin
      st_harm = clamp_signed(128'(xm), xneg, sat);
    end else if (hold == 0) begin
      held = 1'b1;
    end else begin
      hneg = hold < 0;
      hm = magnitude(hold);
      ta = 128'(c) * 128'(xm);
      tb = 128'(hm);
      if (xneg == hneg) begin
        den = ta + tb;
        dneg = xneg;
      end else if (ta >= tb) begin
        den = ta - tb;
        dneg = xneg;
      end else begin
        den = tb - ta;
        dneg = hneg;
      end
      if (den == 0) begin
        held = 1'b1;
      end else begin
        num = 128'(n) * 128'(hm) * 128'(xm);
        st_harm = clamp_signed(div_nearest(num, den), (hneg != xneg) != dneg, sat);
      end
    end

    st_mean = mnew[31:0];
    st_count = n;
    res.count = n[31:0];
    res.std_dev = st_dev;
    res.arith_mean = st_mean;
    res.rms = rms;
    res.hmean = st_harm;
    res.status = held ? rsu_pkg::STAT_HELD : (sat ? rsu_pkg::STAT_SAT : rsu_pkg::STAT_OK);
    return res;
  endfunction

  // receiver: random stalls, long hold-off on request, and result checks
  always @(posedge clk) begin
    static int stall = 0;
    stats_t exp_s;
    logic   nxt;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      if (rst_n && out_ch.valid && out_ch.ready) begin
        stall = idle_on ? $urandom_range(0, 12) : 0;
        if (expected_stats.size() == 0) begin
          $error("result word with no expectation: count %0d", out_ch.count);
          errors++;
        end else begin
          exp_s = expected_stats.pop_front();
          if (out_ch.count !== exp_s.count) begin
            $error("count exp %0d got %0d", exp_s.count, out_ch.count); errors++;
          end
          if (out_ch.std_dev !== exp_s.std_dev) begin
            $error("std_dev exp %h got %h", exp_s.std_dev, out_ch.std_dev); errors++;
          end
          if (out_ch.arith_mean !== exp_s.arith_mean) begin
            $error("arith_mean exp %h got %h", exp_s.arith_mean, out_ch.arith_mean); errors++;
          end
          if (out_ch.rms !== exp_s.rms) begin
            $error("rms exp %h got %h", exp_s.rms, out_ch.rms); errors++;
          end
          if (out_ch.hmean !== exp_s.hmean) begin
            $error("hmean exp %h got %h", exp_s.hmean, out_ch.hmean);
            errors++;
          end
          if (out_ch.status !== exp_s.status) begin
            $error("status exp %0d got %0d", exp_s.status, out_ch.status); errors++;
          end
        end
      end
      if (!rst_n) nxt = 1'b0;
      else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        nxt = 1'b0;
      end else if (stall > 0) begin
        stall--;
        nxt = 1'b0;
      end else nxt = 1'b1;
      out_ch.ready <= nxt;
    end
  end

  task automatic send_word(input logic op, input logic signed [SW-1:0] sample);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.sample <= sample;
    do @(posedge clk); while (!in_ch.ready);
    expected_stats.push_back(update_stats(op, sample));
  endtask

  task automatic drain;
    // drop the last word first so that it is not taken twice
    in_ch.valid <= 1'b0;
    while (expected_stats.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_seeds(input logic [31:0] cnt, mean, harm, dev);
    logic [31:0] vals[4];
    drain();
    vals = '{cnt, mean, harm, dev};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sd_count = cnt;
    sd_mean = mean;
    sd_harm = harm;
    sd_dev = dev;
  endtask

  task automatic restart_from(input logic [31:0] cnt, mean, harm, dev);
    load_seeds(cnt, mean, harm, dev);
    send_word(OP_RESTART, 16'sd0);
  endtask

  task automatic test_empty_start;
    // reset state: first sample fills an empty reciprocal sum
    send_word(OP_SAMPLE, 16'sd7);
    send_word(OP_SAMPLE, 16'sd0);
    send_word(OP_SAMPLE, -16'sd3);
  endtask

  task automatic test_sample_extremes;
    restart_from(32'd0, 32'd0, 32'd0, 32'd0);
    send_word(OP_SAMPLE, 16'sh7FFF);
    send_word(OP_SAMPLE, 16'sh8000);
    send_word(OP_SAMPLE, 16'sd1);
    send_word(OP_SAMPLE, -16'sd1);
    send_word(OP_SAMPLE, 16'sh5555);
    send_word(OP_SAMPLE, 16'shAAAA);
  endtask

  task automatic test_harmonic_held;
    // zero harmonic with a nonzero count
    restart_from(32'd4, 32'h0002_0000, 32'd0, 32'h0001_0000);
    send_word(OP_SAMPLE, 16'sd9);
    // reciprocal sum cancels to zero
    restart_from(32'd1, 32'd0, -32'sd327680, 32'd0);
    send_word(OP_SAMPLE, 16'sd5);
    // held and saturated together
    restart_from(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_word(OP_SAMPLE, 16'sd0);
  endtask

  task automatic test_seed_extremes;
    restart_from(32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_SAMPLE, 16'sh7FFF);
    send_word(OP_SAMPLE, 16'sh8000);
    restart_from(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_SAMPLE, 16'sh8000);
    send_word(OP_SAMPLE, 16'sh7FFF);
    restart_from(32'd1, 32'h8000_0000, 32'h0000_0001, 32'd0);
    send_word(OP_SAMPLE, -16'sd1);
  endtask

  task automatic test_output_backpressure;
    restart_from(32'd0, 32'd0, 32'd0, 32'd0);
    hold_off = 5000;
    for (int i = 0; i < 6; i++) send_word(OP_SAMPLE, SW'($urandom));
  endtask

  task automatic test_random_runs;
    logic [31:0] s[4];
    logic signed [SW-1:0] smp;
    for (int phase = 0; phase < 8; phase++) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 3))
          0: s[k] = '0;
          1: s[k] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
          2: s[k] = $urandom_range(0, 200) << FB;
          default: s[k] = $urandom;
        endcase
      end
      if (s[0] > 32'd1000 && $urandom_range(0, 2) != 0) s[0] = $urandom_range(0, 1000);
      restart_from(s[0], s[1], s[2], s[3]);
      for (int i = 0; i < 240; i++) begin
        if (i % 60 == 0) idle_on = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 39) == 0) begin
          send_word(OP_RESTART, SW'($urandom));
        end else begin
          case ($urandom_range(0, 4))
            0: smp = SW'($urandom);
            1: smp = 16'sh7FFF - SW'($urandom_range(0, 3));
            2: smp = 16'sh8000 + SW'($urandom_range(0, 3));
            3: smp = SW'($urandom_range(0, 20)) - 16'sd10;
            default: smp = SW'($urandom_range(0, 2000)) - 16'sd1000;
          endcase
          send_word(OP_SAMPLE, smp);
        end
      end
      idle_on = 1'b1;
    end
  endtask

  initial begin
    st_count = '0;
    st_mean = '0;
    st_harm = '0;
    st_dev = '0;
    sd_count = '0;
    sd_mean = '0;
    sd_harm = '0;
    sd_dev = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_start();
    test_sample_extremes();
    test_harmonic_held();
    test_seed_extremes();
    test_output_backpressure();
    test_random_runs();
    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/rsu_pkg.sv
rtl/rsu_if.sv
rtl/rsu_alu.sv
rtl/running_statistics_update.sv
bench/testbench.sv
